// ===== hdl/tsa_pkg.sv =====
// Shared types and constants for the text stream annotator.
`default_nettype none
package tsa_pkg;

  localparam int NUMBER_DIGITS    = 10;
  localparam int NUMBER_PAD_WIDTH = 6;
  localparam int CNT_W            = 4 * NUMBER_DIGITS;
  localparam int IDX_MAX          = (NUMBER_DIGITS > NUMBER_PAD_WIDTH) ?
                                    NUMBER_DIGITS : NUMBER_PAD_WIDTH;
  localparam int IDX_W            = $clog2(IDX_MAX);
  localparam logic [IDX_W-1:0] PAD_LAST = IDX_W'(NUMBER_PAD_WIDTH - 1);

  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUMBER_ALL       = 3'd0,
    REG_NUMBER_NONBLANK  = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_ENDS        = 3'd3,
    REG_SHOW_TABS        = 3'd4,
    REG_SHOW_NONPRINTING = 3'd5
  } cfg_reg_t;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_DOLLAR  = 8'd36;
  localparam logic [7:0] CH_DASH    = 8'd45;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_QMARK   = 8'd63;
  localparam logic [7:0] CH_OFFSET  = 8'd64;
  localparam logic [7:0] CH_I       = 8'd73;
  localparam logic [7:0] CH_M       = 8'd77;
  localparam logic [7:0] CH_CARET   = 8'd94;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CH_META_LO = 8'd128;
  localparam logic [7:0] CH_RAW_LO  = 8'd160;

  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_CARET,
    PRE_META
  } pre_t;

  typedef struct packed {
    logic             num_en;
    logic [CNT_W-1:0] count;
    logic             end_en;
    pre_t             pre;
    logic [7:0]       ch;
  } desc_t;

  typedef enum logic [2:0] {
    PH_NUM,
    PH_TAB,
    PH_END,
    PH_META_M,
    PH_META_DASH,
    PH_CARET,
    PH_CHAR
  } phase_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== hdl/tsa_if.sv =====
// Valid/ready channel interfaces for input bytes and annotated output bytes.
`default_nettype none
interface tsa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       start_of_file;

  modport source (output valid, output byte_in, output start_of_file, input ready);
  modport sink   (input valid, input byte_in, input start_of_file, output ready);
endinterface

interface tsa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       last_of_run;

  modport source (output valid, output byte_out, output last_of_run, input ready);
  modport sink   (input valid, input byte_out, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== hdl/text_stream_annotator.sv =====
// Top level of the text stream annotator.
// Usage:
//   in_chan  : one text byte per transaction, with a start-of-file flag.
//   out_chan : the annotated bytes, one per transaction; last_of_run marks
//              the final byte caused by an input byte. A squeezed blank line
//              gives no output transaction at all.
//   cfg_*    : write cfg_wdata to register cfg_index while cfg_we is high.
//              Write only while the block is idle.
// Throughput: the back end sends one output byte per cycle while the receiver
//   keeps up; an input byte produces 1 to 15 output bytes. The front
//   end takes one input byte per cycle while the two-entry descriptor queue
//   has room.
// When nothing is queued ahead of it, an input byte passes through the
//   descriptor queue and then the output register before its first byte is valid.
// Reset (rst_n low, synchronous) clears the options, the line counter and
//   the line-start tracking, and empties the queue and output register.
// A stalled receiver holds the output register; the queue then fills and
//   in_chan.ready drops.
`default_nettype none
module text_stream_annotator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tsa_in_if.sink                             in_chan,
  tsa_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [tsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                          cfg_wdata
);

  tsa_pkg::desc_t   push_desc;
  tsa_pkg::desc_t   head;
  tsa_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;

  tsa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  tsa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head      (head),
    .stat      (q_stat)
  );

  tsa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("descriptor popped from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("descriptor pushed into full queue");

  a_pop_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_chan.valid && out_chan.last_of_run))
    else $error("descriptor retired without its last byte");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.empty && !out_chan.valid) |=> !out_chan.valid)
    else $error("output byte appeared with nothing queued");

endmodule
`default_nettype wire

// ===== hdl/tsa_front.sv =====
// Front end: configuration, line tracking, line counter and byte classification.
`default_nettype none
module tsa_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tsa_in_if.sink                          in_chan,
  input  wire logic                       cfg_we,
  input  wire logic [tsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                       cfg_wdata,
  input  wire tsa_pkg::q_stat_t           q_stat,
  output logic                            q_push,
  output tsa_pkg::desc_t                  q_desc
);

  logic number_all_r;
  logic number_nonblank_r;
  logic squeeze_blank_r;
  logic show_ends_r;
  logic show_tabs_r;
  logic show_nonprinting_r;

  logic                      prev_nl_r;
  logic                      blank_r;
  logic [tsa_pkg::CNT_W-1:0] count_r;
  logic [tsa_pkg::CNT_W-1:0] count_nxt;

  logic       accept;
  logic [7:0] c;
  logic       prev_nl;
  logic       blank_eff;
  logic       is_nl;
  logic       squeeze;
  logic       num_en;

  function automatic logic [tsa_pkg::CNT_W-1:0] bcd_inc(
    input logic [tsa_pkg::CNT_W-1:0] v
  );
    logic                      carry;
    logic [3:0]                d;
    logic [tsa_pkg::CNT_W-1:0] r;
    carry = 1'b1;
    r     = v;
    for (int i = 0; i < tsa_pkg::NUMBER_DIGITS; i++) begin
      d = v[4*i +: 4];
      if (carry) begin
        if (d < 4'd9) begin
          r[4*i +: 4] = d + 4'd1;
          carry       = 1'b0;
        end else begin
          r[4*i +: 4] = 4'd0;
        end
      end
    end
    return r;
  endfunction

  assign in_chan.ready = !q_stat.full;

  always_comb begin
    accept    = in_chan.valid && in_chan.ready;
    c         = in_chan.byte_in;
    prev_nl   = in_chan.start_of_file || prev_nl_r;
    blank_eff = !in_chan.start_of_file && blank_r;
    is_nl     = (c == tsa_pkg::CH_NL);
    squeeze   = squeeze_blank_r && prev_nl && is_nl && blank_eff;
    num_en    = prev_nl && ((number_all_r && !number_nonblank_r) ||
                            (number_nonblank_r && !is_nl));
    count_nxt = bcd_inc(count_r);
    q_push    = accept && !squeeze;
  end

  always_comb begin
    q_desc.num_en = num_en;
    q_desc.count  = count_nxt;
    q_desc.end_en = show_ends_r && is_nl;
    q_desc.pre    = tsa_pkg::PRE_NONE;
    q_desc.ch     = c;
    if (show_tabs_r && (c == tsa_pkg::CH_TAB)) begin
      q_desc.pre = tsa_pkg::PRE_CARET;
      q_desc.ch  = tsa_pkg::CH_I;
    end else if (show_nonprinting_r && !is_nl && (c != tsa_pkg::CH_TAB)) begin
      if (c < tsa_pkg::CH_SPACE) begin
        q_desc.pre = tsa_pkg::PRE_CARET;
        q_desc.ch  = c + tsa_pkg::CH_OFFSET;
      end else if (c == tsa_pkg::CH_DEL) begin
        q_desc.pre = tsa_pkg::PRE_CARET;
        q_desc.ch  = tsa_pkg::CH_QMARK;
      end else if ((c >= tsa_pkg::CH_META_LO) && (c < tsa_pkg::CH_RAW_LO)) begin
        q_desc.pre = tsa_pkg::PRE_META;
        q_desc.ch  = c - tsa_pkg::CH_OFFSET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_all_r       <= 1'b0;
      number_nonblank_r  <= 1'b0;
      squeeze_blank_r    <= 1'b0;
      show_ends_r        <= 1'b0;
      show_tabs_r        <= 1'b0;
      show_nonprinting_r <= 1'b0;
      prev_nl_r          <= 1'b1;
      blank_r            <= 1'b0;
      count_r            <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tsa_pkg::REG_NUMBER_ALL:       number_all_r       <= cfg_wdata;
          tsa_pkg::REG_NUMBER_NONBLANK:  number_nonblank_r  <= cfg_wdata;
          tsa_pkg::REG_SQUEEZE_BLANK:    squeeze_blank_r    <= cfg_wdata;
          tsa_pkg::REG_SHOW_ENDS:        show_ends_r        <= cfg_wdata;
          tsa_pkg::REG_SHOW_TABS:        show_tabs_r        <= cfg_wdata;
          tsa_pkg::REG_SHOW_NONPRINTING: show_nonprinting_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        prev_nl_r <= is_nl;
        blank_r   <= squeeze ? blank_eff : (prev_nl && is_nl);
        if (num_en && !squeeze) begin
          count_r <= count_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tsa_queue.sv =====
// Short descriptor queue between the front and back ends.
`default_nettype none
module tsa_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire tsa_pkg::desc_t push_desc,
  input  wire logic         pop,
  output tsa_pkg::desc_t    head,
  output tsa_pkg::q_stat_t  stat
);

  tsa_pkg::desc_t               mem_r [tsa_pkg::QUEUE_DEPTH];
  logic [tsa_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [tsa_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [tsa_pkg::QCNT_W-1:0]   cnt_r;
  logic                         do_push;
  logic                         do_pop;

  function automatic logic [tsa_pkg::QPTR_W-1:0] ptr_inc(
    input logic [tsa_pkg::QPTR_W-1:0] p
  );
    if (p == tsa_pkg::QPTR_W'(tsa_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    stat.full  = (cnt_r == tsa_pkg::QCNT_W'(tsa_pkg::QUEUE_DEPTH));
    stat.empty = (cnt_r == '0);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    head       = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tsa_back.sv =====
// Back end: sequences the output bytes of each descriptor into the output register.
`default_nettype none
module tsa_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire tsa_pkg::desc_t   head,
  input  wire tsa_pkg::q_stat_t q_stat,
  output logic              q_pop,
  tsa_out_if.source         out_chan
);

  logic                      out_valid_r;
  logic [7:0]                out_byte_r;
  logic                      out_last_r;
  logic                      active_r;
  logic                      active_nxt;
  tsa_pkg::phase_t           phase_r;
  tsa_pkg::phase_t           phase_nxt;
  logic [tsa_pkg::IDX_W-1:0] idx_r;
  logic [tsa_pkg::IDX_W-1:0] idx_nxt;

  tsa_pkg::phase_t           cur_phase;
  logic [tsa_pkg::IDX_W-1:0] cur_idx;
  logic [tsa_pkg::IDX_W-1:0] hi;
  logic [tsa_pkg::IDX_W-1:0] start_idx;
  logic [3:0]                dsel;
  logic                      emit;
  logic [7:0]                byte_nxt;

  function automatic tsa_pkg::phase_t after_end(input tsa_pkg::desc_t d);
    if (d.pre == tsa_pkg::PRE_META) begin
      return tsa_pkg::PH_META_M;
    end
    if (d.pre == tsa_pkg::PRE_CARET) begin
      return tsa_pkg::PH_CARET;
    end
    return tsa_pkg::PH_CHAR;
  endfunction

  function automatic tsa_pkg::phase_t after_num(input tsa_pkg::desc_t d);
    if (d.end_en) begin
      return tsa_pkg::PH_END;
    end
    return after_end(d);
  endfunction

  // highest nonzero digit, column to start from, current digit
  always_comb begin
    hi = '0;
    for (int i = 1; i < tsa_pkg::NUMBER_DIGITS; i++) begin
      if (head.count[4*i +: 4] != 4'd0) begin
        hi = tsa_pkg::IDX_W'(i);
      end
    end
    start_idx = (hi > tsa_pkg::PAD_LAST) ? hi : tsa_pkg::PAD_LAST;
    cur_phase = active_r ? phase_r :
                (head.num_en ? tsa_pkg::PH_NUM : after_num(head));
    cur_idx   = active_r ? idx_r : start_idx;
    dsel      = 4'd0;
    for (int i = 0; i < tsa_pkg::NUMBER_DIGITS; i++) begin
      if (cur_idx == tsa_pkg::IDX_W'(i)) begin
        dsel = head.count[4*i +: 4];
      end
    end
    emit = !q_stat.empty && (!out_valid_r || out_chan.ready);
  end

  // output byte
  always_comb begin
    unique case (cur_phase)
      tsa_pkg::PH_NUM:       byte_nxt = (cur_idx > hi) ? tsa_pkg::CH_SPACE :
                                        (tsa_pkg::CH_ZERO + {4'd0, dsel});
      tsa_pkg::PH_TAB:       byte_nxt = tsa_pkg::CH_TAB;
      tsa_pkg::PH_END:       byte_nxt = tsa_pkg::CH_DOLLAR;
      tsa_pkg::PH_META_M:    byte_nxt = tsa_pkg::CH_M;
      tsa_pkg::PH_META_DASH: byte_nxt = tsa_pkg::CH_DASH;
      tsa_pkg::PH_CARET:     byte_nxt = tsa_pkg::CH_CARET;
      tsa_pkg::PH_CHAR:      byte_nxt = head.ch;
      default:               byte_nxt = head.ch;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt  = cur_phase;
    idx_nxt    = cur_idx;
    active_nxt = active_r;
    q_pop      = 1'b0;
    if (emit) begin
      active_nxt = 1'b1;
      unique case (cur_phase)
        tsa_pkg::PH_NUM: begin
          if (cur_idx == '0) begin
            phase_nxt = tsa_pkg::PH_TAB;
          end else begin
            idx_nxt = cur_idx - 1'b1;
          end
        end
        tsa_pkg::PH_TAB:       phase_nxt = after_num(head);
        tsa_pkg::PH_END:       phase_nxt = after_end(head);
        tsa_pkg::PH_META_M:    phase_nxt = tsa_pkg::PH_META_DASH;
        tsa_pkg::PH_META_DASH: phase_nxt = tsa_pkg::PH_CARET;
        tsa_pkg::PH_CARET:     phase_nxt = tsa_pkg::PH_CHAR;
        tsa_pkg::PH_CHAR: begin
          active_nxt = 1'b0;
          q_pop      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      phase_r     <= tsa_pkg::PH_CHAR;
      idx_r       <= '0;
    end else begin
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_nxt;
      out_last_r <= (cur_phase == tsa_pkg::PH_CHAR);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.byte_out    = out_byte_r;
  assign out_chan.last_of_run = out_last_r;

endmodule
`default_nettype wire

// ===== test/tb_text_stream_annotator.sv =====
// Testbench for text_stream_annotator: directed table and random text checked against a predictor.
`timescale 1ns / 100ps
module tb_text_stream_annotator;

  localparam int LIMIT     = 200000;
  localparam int SETTLE    = 8;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 16;
  localparam logic [tsa_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [tsa_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_RAW,
    EXP_NONE
  } exp_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  typedef struct packed {
    logic                          is_cfg;
    logic [tsa_pkg::CFG_IDX_W-1:0] idx;
    logic [7:0]                    ch;
    logic                          sof;
    exp_kind_t                     kind;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tsa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic cfg_wdata;

  tsa_in_if  in_chan ();
  tsa_out_if out_chan ();

  text_stream_annotator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [5:0]                opts = '0;
  logic [tsa_pkg::CNT_W-1:0] line_bcd = '0;
  logic [7:0]                prev_ch = tsa_pkg::CH_NL;
  logic                      blank_seen = 1'b0;

  out_char_t step_chars[$];
  out_char_t pending_chars[$];
  row_t      rows[$];

  int  failures = 0;
  int  chars_checked = 0;
  int  bytes_sent = 0;
  int  cycles = 0;
  bit  no_idle = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_chan.ready <= no_idle || ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk) begin
    out_char_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected output transaction: byte_out %0h", out_chan.byte_out);
        failures++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_chan.byte_out !== want.ch) begin
          $error("byte_out: expected %0h, got %0h", want.ch, out_chan.byte_out);
          failures++;
        end
        if (out_chan.last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_chan.last_of_run);
          failures++;
        end
      end
    end
  end

  function automatic void put_char(logic [7:0] c);
    out_char_t oc;
    oc.ch   = c;
    oc.last = 1'b0;
    step_chars.push_back(oc);
  endfunction

  // Works out the output bytes for one input byte and advances the line state.
  function automatic void annotate_byte(logic [7:0] ch, logic sof);
    logic       prev_nl;
    logic       is_nl;
    logic       carry;
    logic [7:0] c;
    int         hi;
    step_chars.delete();
    if (sof) begin
      prev_ch    = tsa_pkg::CH_NL;
      blank_seen = 1'b0;
    end
    prev_nl = (prev_ch == tsa_pkg::CH_NL);
    is_nl   = (ch == tsa_pkg::CH_NL);
    prev_ch = ch;
    if (opts[tsa_pkg::REG_SQUEEZE_BLANK] && prev_nl && is_nl && blank_seen) return;
    blank_seen = prev_nl && is_nl;
    if (prev_nl && ((opts[tsa_pkg::REG_NUMBER_ALL] && !opts[tsa_pkg::REG_NUMBER_NONBLANK]) ||
                    (opts[tsa_pkg::REG_NUMBER_NONBLANK] && !is_nl))) begin
      carry = 1'b1;
      for (int i = 0; i < tsa_pkg::NUMBER_DIGITS; i++) begin
        if (carry) begin
          if (line_bcd[4*i +: 4] < 4'd9) begin
            line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
            carry = 1'b0;
          end else begin
            line_bcd[4*i +: 4] = 4'd0;
          end
        end
      end
      hi = 0;
      for (int i = tsa_pkg::NUMBER_DIGITS - 1; i > 0; i--) begin
        if (hi == 0 && line_bcd[4*i +: 4] != 4'd0) hi = i;
      end
      for (int pad = hi + 1; pad < tsa_pkg::NUMBER_PAD_WIDTH; pad++)
        put_char(tsa_pkg::CH_SPACE);
      for (int i = hi; i >= 0; i--)
        put_char(tsa_pkg::CH_ZERO + {4'd0, line_bcd[4*i +: 4]});
      put_char(tsa_pkg::CH_TAB);
    end
    if (opts[tsa_pkg::REG_SHOW_ENDS] && is_nl) put_char(tsa_pkg::CH_DOLLAR);
    c = ch;
    if (opts[tsa_pkg::REG_SHOW_TABS] && c == tsa_pkg::CH_TAB) begin
      put_char(tsa_pkg::CH_CARET);
      c = tsa_pkg::CH_I;
    end
    if (opts[tsa_pkg::REG_SHOW_NONPRINTING] && c != tsa_pkg::CH_NL &&
        c != tsa_pkg::CH_TAB) begin
      if (c < tsa_pkg::CH_SPACE) begin
        put_char(tsa_pkg::CH_CARET);
        c = c + tsa_pkg::CH_OFFSET;
      end else if (c == tsa_pkg::CH_DEL) begin
        put_char(tsa_pkg::CH_CARET);
        c = tsa_pkg::CH_QMARK;
      end else if (c >= tsa_pkg::CH_META_LO && c < tsa_pkg::CH_RAW_LO) begin
        put_char(tsa_pkg::CH_M);
        put_char(tsa_pkg::CH_DASH);
        put_char(tsa_pkg::CH_CARET);
        c = c - tsa_pkg::CH_OFFSET;
      end
    end
    put_char(c);
    step_chars[step_chars.size() - 1].last = 1'b1;
  endfunction

  function automatic row_t cfg_row(logic [tsa_pkg::CFG_IDX_W-1:0] idx, logic val);
    row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.ch     = {7'd0, val};
    return r;
  endfunction

  function automatic row_t byte_row(logic [7:0] ch, logic sof, exp_kind_t kind);
    row_t r;
    r      = '0;
    r.ch   = ch;
    r.sof  = sof;
    r.kind = kind;
    return r;
  endfunction

  // Mostly text-like bytes, with plenty of newlines so blank runs occur.
  function automatic logic [7:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return tsa_pkg::CH_NL;
    if (r < 35) return tsa_pkg::CH_TAB;
    if (r < 45) return 8'($urandom_range(0, 31));
    if (r < 50) return tsa_pkg::CH_DEL;
    if (r < 60) return 8'($urandom_range(128, 159));
    if (r < 70) return 8'($urandom_range(160, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic write_reg(logic [tsa_pkg::CFG_IDX_W-1:0] idx, logic val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx <= tsa_pkg::REG_SHOW_NONPRINTING) opts[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until all output has drained and the block has gone quiet.
  task automatic quiesce();
    in_chan.valid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] ch, logic sof, exp_kind_t kind);
    out_char_t oc;
    while (!no_idle && $urandom_range(0, 99) < 26) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.byte_in       <= ch;
    in_chan.start_of_file <= sof;
    do @(posedge clk); while (!in_chan.ready);
    annotate_byte(ch, sof);
    case (kind)
      EXP_MODEL: foreach (step_chars[k]) pending_chars.push_back(step_chars[k]);
      EXP_RAW: begin
        oc.ch   = ch;
        oc.last = 1'b1;
        pending_chars.push_back(oc);
      end
      default: ;
    endcase
    bytes_sent++;
    @(negedge clk);
  endtask

  initial begin
    logic [5:0] settings;
    bit         in_cfg;
    in_chan.valid         = 1'b0;
    in_chan.byte_in       = 8'd0;
    in_chan.start_of_file = 1'b0;
    out_chan.ready        = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = 1'b0;
    rst_n                 = 1'b0;
    in_cfg                = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // all options off after reset: bytes pass through
    rows.push_back(byte_row(8'h41, 1'b1, EXP_RAW));
    rows.push_back(byte_row(8'hFF, 1'b0, EXP_RAW));
    rows.push_back(byte_row(8'h00, 1'b0, EXP_RAW));
    rows.push_back(byte_row(tsa_pkg::CH_NL, 1'b0, EXP_RAW));
    rows.push_back(cfg_row(tsa_pkg::REG_NUMBER_ALL, 1'b1));
    rows.push_back(cfg_row(tsa_pkg::REG_SHOW_ENDS, 1'b1));
    rows.push_back(cfg_row(tsa_pkg::REG_SHOW_TABS, 1'b1));
    rows.push_back(cfg_row(tsa_pkg::REG_SHOW_NONPRINTING, 1'b1));
    rows.push_back(byte_row(8'h00, 1'b1, EXP_MODEL));
    rows.push_back(byte_row(tsa_pkg::CH_DEL, 1'b0, EXP_MODEL));
    rows.push_back(byte_row(tsa_pkg::CH_META_LO, 1'b0, EXP_MODEL));
    rows.push_back(byte_row(8'h9F, 1'b0, EXP_MODEL));
    rows.push_back(byte_row(tsa_pkg::CH_RAW_LO, 1'b0, EXP_RAW));
    rows.push_back(byte_row(tsa_pkg::CH_TAB, 1'b0, EXP_MODEL));
    rows.push_back(byte_row(tsa_pkg::CH_NL, 1'b0, EXP_MODEL));
    // non-blank numbering overrides, blank runs squeezed
    rows.push_back(cfg_row(tsa_pkg::REG_NUMBER_NONBLANK, 1'b1));
    rows.push_back(cfg_row(tsa_pkg::REG_SQUEEZE_BLANK, 1'b1));
    rows.push_back(byte_row(tsa_pkg::CH_NL, 1'b0, EXP_MODEL));
    rows.push_back(byte_row(tsa_pkg::CH_NL, 1'b0, EXP_NONE));
    rows.push_back(byte_row(tsa_pkg::CH_NL, 1'b0, EXP_NONE));
    rows.push_back(byte_row(8'h78, 1'b1, EXP_MODEL));
    rows.push_back(byte_row(tsa_pkg::CH_NL, 1'b0, EXP_MODEL));
    rows.push_back(byte_row(tsa_pkg::CH_NL, 1'b1, EXP_MODEL));
    rows.push_back(cfg_row(tsa_pkg::REG_SHOW_TABS, 1'b0));
    rows.push_back(cfg_row(tsa_pkg::REG_SHOW_ENDS, 1'b0));
    rows.push_back(cfg_row(tsa_pkg::REG_SQUEEZE_BLANK, 1'b0));
    rows.push_back(cfg_row(tsa_pkg::REG_NUMBER_NONBLANK, 1'b0));
    rows.push_back(cfg_row(tsa_pkg::REG_NUMBER_ALL, 1'b0));
    rows.push_back(cfg_row(REG_UNMAPPED_LO, 1'b1));
    rows.push_back(cfg_row(REG_UNMAPPED_HI, 1'b1));
    // tab untouched by caret notation alone
    rows.push_back(byte_row(tsa_pkg::CH_TAB, 1'b0, EXP_RAW));
    rows.push_back(byte_row(8'h1F, 1'b0, EXP_MODEL));
    rows.push_back(byte_row(8'h7E, 1'b0, EXP_RAW));
    rows.push_back(cfg_row(tsa_pkg::REG_SHOW_NONPRINTING, 1'b0));
    rows.push_back(byte_row(tsa_pkg::CH_META_LO, 1'b0, EXP_RAW));
    rows.push_back(byte_row(tsa_pkg::CH_DEL, 1'b0, EXP_RAW));
    rows.push_back(byte_row(tsa_pkg::CH_NL, 1'b0, EXP_RAW));

    foreach (rows[r]) begin
      if (rows[r].is_cfg) begin
        if (!in_cfg) quiesce();
        write_reg(rows[r].idx, rows[r].ch[0]);
      end else begin
        send_byte(rows[r].ch, rows[r].sof, rows[r].kind);
      end
      in_cfg = rows[r].is_cfg;
    end

    for (int p = 0; p < PHASES; p++) begin
      settings = (p == 0) ? 6'h3F : (p == 1) ? 6'h00 : 6'($urandom);
      quiesce();
      for (int i = 0; i < 6; i++) write_reg(tsa_pkg::CFG_IDX_W'(i), settings[i]);
      no_idle = (p == 2);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (p == 4 && i == PHASE_LEN / 2) quiesce();
        send_byte(random_char(), $urandom_range(0, 19) == 0, EXP_MODEL);
      end
    end
    no_idle = 0;

    quiesce();
    repeat (12) @(negedge clk);
    $display("%0d bytes sent, %0d output transactions checked, %0d option sets",
             bytes_sent, chars_checked, PHASES);
    $display("line counter reached %0h; %0d mismatches", line_bcd, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tsa_pkg.sv
hdl/tsa_if.sv
hdl/tsa_front.sv
hdl/tsa_queue.sv
hdl/tsa_back.sv
hdl/text_stream_annotator.sv
test/tb_text_stream_annotator.sv
